[hw/rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants of the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  // CORDIC datapath word: Q1.30 for x and y, 2^32 per turn for z, with headroom.
  typedef logic signed [33:0] cval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } cordic_t;

  // One lane per angle: roll, pitch, yaw.
  typedef cordic_t [2:0] lanes_t;

  typedef logic signed [31:0] trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sincos_t;

  typedef sincos_t [2:0] sc_t;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // Initial x of the rotation: the CORDIC gain compensation in Q1.30.
  localparam cval_t CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in units of 2^32 per turn, rounded to nearest.
  localparam logic [33:0] ATAN_TURN32 [0:31] = '{
    34'd536870912, 34'd316933406, 34'd167458907, 34'd85004756, 34'd42667331,
    34'd21354465, 34'd10679838, 34'd5340245, 34'd2670163, 34'd1335087,
    34'd667544, 34'd333772, 34'd166886, 34'd83443, 34'd41722, 34'd20861,
    34'd10430, 34'd5215, 34'd2608, 34'd1304, 34'd652, 34'd326, 34'd163,
    34'd81, 34'd41, 34'd20, 34'd10, 34'd5, 34'd3, 34'd1, 34'd1, 34'd0
  };

endpackage

`default_nettype wire

[hw/rtl/e2q_cordic_stage.sv]
// ----------------------------------------------------------------------------
// e2q_cordic_stage
// One registered micro-rotation, applied to all three angle lanes at once.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire e2q_pkg::lanes_t in_lanes,
  output logic                 out_valid,
  output e2q_pkg::lanes_t      out_lanes
);

  localparam e2q_pkg::cval_t ATAN_I = e2q_pkg::cval_t'(e2q_pkg::ATAN_TURN32[SHIFT]);

  logic            valid_r;
  e2q_pkg::lanes_t lanes_r;
  e2q_pkg::lanes_t lanes_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!in_lanes[l].z[33]) begin
        lanes_nxt[l].x = in_lanes[l].x - (in_lanes[l].y >>> SHIFT);
        lanes_nxt[l].y = in_lanes[l].y + (in_lanes[l].x >>> SHIFT);
        lanes_nxt[l].z = in_lanes[l].z - ATAN_I;
      end else begin
        lanes_nxt[l].x = in_lanes[l].x + (in_lanes[l].y >>> SHIFT);
        lanes_nxt[l].y = in_lanes[l].y - (in_lanes[l].x >>> SHIFT);
        lanes_nxt[l].z = in_lanes[l].z + ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    lanes_r <= lanes_nxt;
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

endmodule

`default_nettype wire

[hw/rtl/e2q_cordic.sv]
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine of three half angles.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire e2q_pkg::cval_t [2:0]  in_angle,
  output logic                       out_valid,
  output e2q_pkg::sc_t               out_sc
);

  e2q_pkg::lanes_t chain [0:STAGES];
  logic            vchain [0:STAGES];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      chain[0][l].x = e2q_pkg::CORDIC_GAIN;
      chain[0][l].y = '0;
      chain[0][l].z = in_angle[l];
    end
  end
  assign vchain[0] = in_valid;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    e2q_cordic_stage #(.SHIFT(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vchain[i]),
      .in_lanes  (chain[i]),
      .out_valid (vchain[i+1]),
      .out_lanes (chain[i+1])
    );
  end

  // Final magnitudes stay near 2^30, so 32 bits hold cosine and sine.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_sc[l].c = chain[STAGES][l].x[31:0];
      out_sc[l].s = chain[STAGES][l].y[31:0];
    end
  end
  assign out_valid = vchain[STAGES];

endmodule

`default_nettype wire

[hw/rtl/e2q_quat_math.sv]
// ----------------------------------------------------------------------------
// e2q_quat_math
// Three-stage product, sum, rounding and saturation of the quaternion terms.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_quat_math (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire e2q_pkg::sc_t       in_sc,
  output logic                    out_valid,
  output logic signed [15:0]      out_w,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z
);

  // Pair products: crcp, srsp, srcp, crsp.
  localparam int P_CC = 0;
  localparam int P_SS = 1;
  localparam int P_SC = 2;
  localparam int P_CS = 3;

  logic               va_r, vb_r, vc_r;
  e2q_pkg::trig_t     p_r [4];
  logic signed [63:0] m1  [4];
  e2q_pkg::sincos_t   yaw_r;

  // Second products: index 2*k times cy, 2*k+1 times sy.
  logic signed [33:0] q_r [8];
  logic signed [63:0] m2  [8];

  logic signed [15:0] res_r [4];
  logic signed [34:0] sum   [4];

  function automatic logic signed [15:0] to_q14(input logic signed [34:0] s);
    logic signed [34:0] r;
    logic signed [18:0] v;
    r = s + 35'sd32768;
    v = r[34:16];
    if (v > 19'sd16384) begin
      return 16'sd16384;
    end else if (v < -19'sd16384) begin
      return -16'sd16384;
    end else begin
      return v[15:0];
    end
  endfunction

  assign m1[P_CC] = in_sc[e2q_pkg::LANE_ROLL].c * in_sc[e2q_pkg::LANE_PITCH].c;
  assign m1[P_SS] = in_sc[e2q_pkg::LANE_ROLL].s * in_sc[e2q_pkg::LANE_PITCH].s;
  assign m1[P_SC] = in_sc[e2q_pkg::LANE_ROLL].s * in_sc[e2q_pkg::LANE_PITCH].c;
  assign m1[P_CS] = in_sc[e2q_pkg::LANE_ROLL].c * in_sc[e2q_pkg::LANE_PITCH].s;

  for (genvar k = 0; k < 4; k++) begin : g_m2
    assign m2[2*k]   = p_r[k] * yaw_r.c;
    assign m2[2*k+1] = p_r[k] * yaw_r.s;
  end

  assign sum[0] = 35'(q_r[2*P_CC])   + 35'(q_r[2*P_SS+1]);
  assign sum[1] = 35'(q_r[2*P_SC])   - 35'(q_r[2*P_CS+1]);
  assign sum[2] = 35'(q_r[2*P_CS])   + 35'(q_r[2*P_SC+1]);
  assign sum[3] = 35'(q_r[2*P_CC+1]) - 35'(q_r[2*P_SS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
    for (int k = 0; k < 4; k++) begin
      p_r[k] <= m1[k][61:30];
    end
    yaw_r <= in_sc[e2q_pkg::LANE_YAW];
    for (int k = 0; k < 8; k++) begin
      q_r[k] <= m2[k][63:30];
    end
    for (int k = 0; k < 4; k++) begin
      res_r[k] <= to_q14(sum[k]);
    end
  end

  assign out_valid = vc_r;
  assign out_w = res_r[0];
  assign out_x = res_r[1];
  assign out_y = res_r[2];
  assign out_z = res_r[3];

endmodule

`default_nettype wire

[hw/rtl/euler_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Converts roll, pitch and yaw binary angles to a unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake           Payload
//   input    start / busy        in_roll_angle, in_pitch_angle, in_yaw_angle
//   result   out_valid (strobe)  out_quat_w, out_quat_x, out_quat_y, out_quat_z
//
// A new beat is accepted every cycle; busy is always low.
// The stages are one input register that halves the angles, one register
// per CORDIC micro-rotation, two multiplier stages and one rounding and
// saturation stage.
// Reset clears only the valid bits of the pipeline; data registers run free.
// The receiver cannot stall, so the pipeline never holds; each result is on
// the outputs for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion_unit #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_roll_angle,
  input  wire logic signed [15:0] in_pitch_angle,
  input  wire logic signed [15:0] in_yaw_angle,
  output logic                    out_valid,
  output logic signed [15:0]      out_quat_w,
  output logic signed [15:0]      out_quat_x,
  output logic signed [15:0]      out_quat_y,
  output logic signed [15:0]      out_quat_z
);

  // Only the low ANGLE_BITS bits of each field count; they are moved to the
  // top of a 32-bit phase where a full turn is 2^32.
  localparam logic [63:0] ANGLE_MASK = (64'd1 << ANGLE_BITS) - 64'd1;
  localparam int          PH_SHIFT   = 32 - ANGLE_BITS;

  logic                      valid_r;
  e2q_pkg::cval_t [2:0]      half_r;
  e2q_pkg::cval_t [2:0]      half_nxt;
  logic [15:0]               raw [3];
  logic                      sc_valid;
  e2q_pkg::sc_t              sc;

  assign busy = 1'b0;

  assign raw[e2q_pkg::LANE_ROLL]  = in_roll_angle;
  assign raw[e2q_pkg::LANE_PITCH] = in_pitch_angle;
  assign raw[e2q_pkg::LANE_YAW]   = in_yaw_angle;

  // Halving the signed phase is an arithmetic shift right by one.
  always_comb begin
    logic [31:0] ph;
    for (int l = 0; l < 3; l++) begin
      ph = 32'((64'(raw[l]) & ANGLE_MASK) << PH_SHIFT);
      half_nxt[l] = e2q_pkg::cval_t'($signed(ph) >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start;
    end
    half_r <= half_nxt;
  end

  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_r),
    .in_angle  (half_r),
    .out_valid (sc_valid),
    .out_sc    (sc)
  );

  e2q_quat_math u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_sc     (sc),
    .out_valid (out_valid),
    .out_w     (out_quat_w),
    .out_x     (out_quat_x),
    .out_y     (out_quat_y),
    .out_z     (out_quat_z)
  );

endmodule

`default_nettype wire
